// ----- hw/rtl/kce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kce_pkg;

	localparam int DEF_MAX_POINTS   = 1024;
	localparam int DEF_FEATURES     = 4;
	localparam int DEF_MAX_CLUSTERS = 16;

	localparam logic [2:0] KIND_LOAD_POINT    = 3'd0;
	localparam logic [2:0] KIND_LOAD_CENTROID = 3'd1;
	localparam logic [2:0] KIND_RUN           = 3'd2;
	localparam logic [2:0] KIND_READ_CENTROID = 3'd3;
	localparam logic [2:0] KIND_READ_CLUSTER  = 3'd4;

	localparam logic [1:0] REG_NUM_POINTS     = 2'd0;
	localparam logic [1:0] REG_NUM_CLUSTERS   = 2'd1;
	localparam logic [1:0] REG_MAX_ITERATIONS = 2'd2;
	localparam logic [1:0] REG_THRESHOLD      = 2'd3;

	localparam logic [10:0] RST_NUM_POINTS     = 11'd1;
	localparam logic [4:0]  RST_NUM_CLUSTERS   = 5'd2;
	localparam logic [15:0] RST_MAX_ITERATIONS = 16'd100;
	localparam logic [30:0] RST_THRESHOLD      = 31'd66;

	typedef enum logic [21:0] {
		ST_CLEAR = 22'h000001,
		ST_IDLE  = 22'h000002,
		ST_INIT  = 22'h000004,
		ST_THR1  = 22'h000008,
		ST_THR2  = 22'h000010,
		ST_PASS  = 22'h000020,
		ST_ARD   = 22'h000040,
		ST_ADIF  = 22'h000080,
		ST_AMUL  = 22'h000100,
		ST_AACC  = 22'h000200,
		ST_SCLR  = 22'h000400,
		ST_URA   = 22'h000800,
		ST_URC   = 22'h001000,
		ST_UFR   = 22'h002000,
		ST_UFW   = 22'h004000,
		ST_DRD   = 22'h008000,
		ST_DLD   = 22'h010000,
		ST_DDIV  = 22'h020000,
		ST_DDIF  = 22'h040000,
		ST_DMUL  = 22'h080000,
		ST_DACC  = 22'h100000,
		ST_DEND  = 22'h200000
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kce_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/kce_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kce_div #(
	parameter int SUM_W = 42,
	parameter int CNT_W = 11
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic        [CNT_W-1:0] divisor,
	output logic                         done,
	output logic             [31:0]      quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    rs;
	logic [CNT_W:0]    rdiff;
	logic              ge;

	always_comb begin
		rs    = {rem_q, quo_q[SUM_W-1]};
		rdiff = rs - {1'b0, dvs_q};
		ge    = rs >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rdiff[CNT_W-1:0] : rs[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q[31:0] : quo_q[31:0];

endmodule
`default_nettype wire

// ----- hw/rtl/kmeans_clustering_engine_unit.sv -----
// Lloyd k-means engine over signed Q16.16 features.
// Input channel (in_valid/in_ready) carries one transaction per item: kind, slot,
// feature_index and value. Loads of point and centroid features produce no result
// and stream one per cycle while no result waits in the output register. A read
// is held in pend_s1 and then raises out_valid from the output register; no new
// transaction is taken while it is held in pend_s1. A run transaction produces
// one result with iterations_done and converged. A pass assigns the points, clears
// the K*F sums, accumulates them and computes the new centroids, where the
// bit-serial divider (one quotient bit per cycle) dominates the update.
// One multiplier serves every square; the threshold is squared once per run.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. After reset the block clears the assignment and centroid stores,
// one entry per cycle, and in_ready stays low until that pass ends. Point features are undefined
// until loaded.
// The result waits in an output register while out_ready is low; no new
// transaction is taken until that register drains.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_clustering_engine_unit
	import kce_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int FEATURES     = DEF_FEATURES,
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  kind,
	input  wire logic        [9:0]  slot,
	input  wire logic        [2:0]  feature_index,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [15:0] iterations_done,
	output logic                    converged,
	output logic signed      [31:0] read_value,
	output logic             [3:0]  read_cluster,
	input  wire logic               cfg_we,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [30:0] cfg_data
);

	localparam int F_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int PA_W  = $clog2(MAX_POINTS * FEATURES);
	localparam int AI_W  = $clog2(MAX_POINTS);
	localparam int CI_W  = $clog2(MAX_CLUSTERS);
	localparam int CA_W  = (MAX_CLUSTERS * FEATURES > 1) ? $clog2(MAX_CLUSTERS * FEATURES) : 1;
	localparam int NP_W  = $clog2(MAX_POINTS + 1);
	localparam int KC_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int SUM_W = 32 + AI_W;
	localparam int CLR_N = (MAX_POINTS > MAX_CLUSTERS * FEATURES) ?
		MAX_POINTS : MAX_CLUSTERS * FEATURES;
	localparam int CLR_W = $clog2(CLR_N);

	state_t state_q;

	logic [10:0] num_points_q;
	logic [4:0]  num_clusters_q;
	logic [15:0] max_iter_q;
	logic [30:0] thr_q;

	logic [NP_W-1:0]  i_q;
	logic [KC_W-1:0]  c_q;
	logic [F_W-1:0]   f_q;
	logic [CI_W-1:0]  cc_q;
	logic [CI_W-1:0]  best_c_q;
	logic [63:0]      best_q;
	logic [63:0]      acc_q;
	logic [63:0]      maxs_q;
	logic [63:0]      thr_sq_q;
	logic [31:0]      mag_q;
	logic [63:0]      prod_q;
	logic [15:0]      it_q;
	logic [CLR_W-1:0] clr_q;
	logic [CA_W:0]    sc_q;
	logic signed [31:0] old_q;
	logic signed [31:0] fresh_q;
	logic [NP_W-1:0]  cnt_q [MAX_CLUSTERS];

	logic       pend_s1;
	logic       pend_cent_s1;
	logic       pend_ok_s1;

	logic              out_valid_q;
	logic [15:0]       it_out_q;
	logic              conv_out_q;
	logic signed [31:0] rv_out_q;
	logic [3:0]        rc_out_q;

	logic [NP_W-1:0] n_eff;
	logic [KC_W-1:0] k_eff;
	logic            in_fire;
	logic            f_ok;
	logic            pslot_ok;
	logic            cslot_ok;
	logic            f_last;
	logic            c_last;
	logic            i_last;
	logic            sc_last;
	logic [31:0]     pa_in;
	logic [31:0]     ca_in;
	logic [31:0]     pa_run;
	logic [31:0]     ca_run;
	logic [31:0]     ca_acc;

	logic            pt_we;
	logic [PA_W-1:0] pt_waddr;
	logic [PA_W-1:0] pt_raddr;
	logic [31:0]     pt_rd;
	logic            as_we;
	logic [AI_W-1:0] as_waddr;
	logic [CI_W-1:0] as_wdata;
	logic [AI_W-1:0] as_raddr;
	logic [CI_W-1:0] as_rd;
	logic            ce_we;
	logic [CA_W-1:0] ce_waddr;
	logic [31:0]     ce_wdata;
	logic [CA_W-1:0] ce_raddr;
	logic [31:0]     ce_rd;
	logic              su_we;
	logic [CA_W-1:0]   su_waddr;
	logic [SUM_W-1:0]  su_wdata;
	logic [CA_W-1:0]   su_raddr;
	logic [SUM_W-1:0]  su_rd;

	logic [CI_W-1:0] cnt_idx;
	logic [NP_W-1:0] cnt_rd;
	logic            div_start;
	logic            div_done;
	logic [31:0]     div_q;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [32:0] dif;
	logic [32:0]        dif_mag;
	logic [64:0]        acc_sum;
	logic [63:0]        acc_next;
	logic               better;
	logic [31:0]        rc_ext;

	always_comb begin
		n_eff = (32'(num_points_q) > MAX_POINTS) ? NP_W'(MAX_POINTS) : NP_W'(num_points_q);
		if (num_clusters_q == 5'd0) begin
			k_eff = KC_W'(1);
		end else if (32'(num_clusters_q) > MAX_CLUSTERS) begin
			k_eff = KC_W'(MAX_CLUSTERS);
		end else begin
			k_eff = KC_W'(num_clusters_q);
		end
		in_ready = (state_q == ST_IDLE) && !pend_s1 && (!out_valid_q || out_ready);
		in_fire  = in_valid && in_ready;
		f_ok     = 32'(feature_index) < FEATURES;
		pslot_ok = 32'(slot) < MAX_POINTS;
		cslot_ok = 32'(slot) < MAX_CLUSTERS;
		f_last   = 32'(f_q) == FEATURES - 1;
		c_last   = 32'(c_q) == 32'(k_eff) - 1;
		i_last   = 32'(i_q) == 32'(n_eff) - 1;
		sc_last  = 32'(sc_q) == 32'(k_eff) * FEATURES - 1;
		pa_in    = 32'(slot) * FEATURES + 32'(feature_index);
		ca_in    = 32'(slot) * FEATURES + 32'(feature_index);
		pa_run   = 32'(i_q) * FEATURES + 32'(f_q);
		ca_run   = 32'(c_q) * FEATURES + 32'(f_q);
		ca_acc   = 32'(cc_q) * FEATURES + 32'(f_q);
		rc_ext   = 32'(as_rd);

		if (state_q == ST_DDIF) begin
			op_a = old_q;
			op_b = fresh_q;
		end else begin
			op_a = pt_rd;
			op_b = ce_rd;
		end
		dif      = 33'(op_a) - 33'(op_b);
		dif_mag  = dif[32] ? -dif : dif;
		acc_sum  = {1'b0, acc_q} + {1'b0, prod_q};
		acc_next = acc_sum[64] ? '1 : acc_sum[63:0];
		better   = (c_q == '0) || (acc_next < best_q);

		cnt_idx = (state_q == ST_URC) ? as_rd : c_q[CI_W-1:0];
		cnt_rd  = cnt_q[cnt_idx];
		div_start = (state_q == ST_DLD) && (cnt_rd != '0);

		pt_we    = in_fire && (kind == KIND_LOAD_POINT) && f_ok && pslot_ok;
		pt_waddr = pa_in[PA_W-1:0];
		pt_raddr = pa_run[PA_W-1:0];

		as_we    = 1'b0;
		as_waddr = i_q[AI_W-1:0];
		as_wdata = better ? c_q[CI_W-1:0] : best_c_q;
		as_raddr = (state_q == ST_IDLE) ? slot[AI_W-1:0] : i_q[AI_W-1:0];

		ce_we    = 1'b0;
		ce_waddr = ca_run[CA_W-1:0];
		ce_wdata = fresh_q;
		ce_raddr = (state_q == ST_IDLE) ? ca_in[CA_W-1:0] : ca_run[CA_W-1:0];

		su_we    = 1'b0;
		su_waddr = ca_acc[CA_W-1:0];
		su_wdata = su_rd + SUM_W'(signed'(pt_rd));
		su_raddr = (state_q == ST_UFR) ? ca_acc[CA_W-1:0] : ca_run[CA_W-1:0];

		case (state_q)
			ST_CLEAR: begin
				as_we    = 32'(clr_q) < MAX_POINTS;
				as_waddr = clr_q[AI_W-1:0];
				as_wdata = '0;
				ce_we    = 32'(clr_q) < MAX_CLUSTERS * FEATURES;
				ce_waddr = clr_q[CA_W-1:0];
				ce_wdata = '0;
			end
			ST_IDLE: begin
				ce_we    = in_fire && (kind == KIND_LOAD_CENTROID) && f_ok && cslot_ok;
				ce_waddr = ca_in[CA_W-1:0];
				ce_wdata = value;
			end
			ST_AACC: begin
				as_we = f_last && c_last;
			end
			ST_SCLR: begin
				su_we    = 1'b1;
				su_waddr = sc_q[CA_W-1:0];
				su_wdata = '0;
			end
			ST_UFW: begin
				su_we = 1'b1;
			end
			ST_DDIF: begin
				ce_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mag_q) * 64'(mag_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			num_points_q   <= RST_NUM_POINTS;
			num_clusters_q <= RST_NUM_CLUSTERS;
			max_iter_q     <= RST_MAX_ITERATIONS;
			thr_q          <= RST_THRESHOLD;
			clr_q          <= '0;
			pend_s1        <= 1'b0;
			out_valid_q    <= 1'b0;
			for (int j = 0; j < MAX_CLUSTERS; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_POINTS:     num_points_q   <= cfg_data[10:0];
					REG_NUM_CLUSTERS:   num_clusters_q <= cfg_data[4:0];
					REG_MAX_ITERATIONS: max_iter_q     <= cfg_data[15:0];
					REG_THRESHOLD:      thr_q          <= cfg_data;
					default: begin
					end
				endcase
			end

			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (pend_s1) begin
				pend_s1     <= 1'b0;
				it_out_q    <= '0;
				conv_out_q  <= 1'b0;
				rv_out_q    <= (pend_cent_s1 && pend_ok_s1) ? ce_rd : '0;
				rc_out_q    <= (!pend_cent_s1 && pend_ok_s1) ? rc_ext[3:0] : 4'd0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == CLR_N - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (kind)
							KIND_RUN: begin
								state_q <= ST_INIT;
							end
							KIND_READ_CENTROID: begin
								pend_s1      <= 1'b1;
								pend_cent_s1 <= 1'b1;
								pend_ok_s1   <= f_ok && cslot_ok;
							end
							KIND_READ_CLUSTER: begin
								pend_s1      <= 1'b1;
								pend_cent_s1 <= 1'b0;
								pend_ok_s1   <= pslot_ok;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INIT: begin
					mag_q <= {1'b0, thr_q};
					it_q  <= '0;
					if (max_iter_q == 16'd0) begin
						out_valid_q <= 1'b1;
						it_out_q    <= '0;
						conv_out_q  <= 1'b0;
						rv_out_q    <= '0;
						rc_out_q    <= '0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_THR1;
					end
				end
				ST_THR1: begin
					state_q <= ST_THR2;
				end
				ST_THR2: begin
					thr_sq_q <= prod_q;
					state_q  <= ST_PASS;
				end
				ST_PASS: begin
					i_q   <= '0;
					c_q   <= '0;
					f_q   <= '0;
					acc_q <= '0;
					sc_q  <= '0;
					state_q <= (n_eff == '0) ? ST_SCLR : ST_ARD;
				end
				ST_ARD: begin
					state_q <= ST_ADIF;
				end
				ST_ADIF: begin
					mag_q   <= dif_mag[31:0];
					state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					state_q <= ST_AACC;
				end
				ST_AACC: begin
					if (!f_last) begin
						acc_q   <= acc_next;
						f_q     <= f_q + 1'b1;
						state_q <= ST_ARD;
					end else begin
						acc_q <= '0;
						f_q   <= '0;
						if (better) begin
							best_q   <= acc_next;
							best_c_q <= c_q[CI_W-1:0];
						end
						if (!c_last) begin
							c_q     <= c_q + 1'b1;
							state_q <= ST_ARD;
						end else begin
							c_q <= '0;
							if (!i_last) begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_ARD;
							end else begin
								i_q     <= '0;
								state_q <= ST_SCLR;
							end
						end
					end
				end
				ST_SCLR: begin
					for (int j = 0; j < MAX_CLUSTERS; j++) begin
						cnt_q[j] <= '0;
					end
					sc_q <= sc_q + 1'b1;
					if (sc_last) begin
						c_q    <= '0;
						f_q    <= '0;
						acc_q  <= '0;
						maxs_q <= '0;
						state_q <= (n_eff == '0) ? ST_DRD : ST_URA;
					end
				end
				ST_URA: begin
					state_q <= ST_URC;
				end
				ST_URC: begin
					cc_q           <= as_rd;
					cnt_q[cnt_idx] <= cnt_rd + 1'b1;
					f_q            <= '0;
					state_q        <= ST_UFR;
				end
				ST_UFR: begin
					state_q <= ST_UFW;
				end
				ST_UFW: begin
					if (!f_last) begin
						f_q     <= f_q + 1'b1;
						state_q <= ST_UFR;
					end else if (!i_last) begin
						f_q     <= '0;
						i_q     <= i_q + 1'b1;
						state_q <= ST_URA;
					end else begin
						f_q     <= '0;
						c_q     <= '0;
						acc_q   <= '0;
						maxs_q  <= '0;
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					state_q <= ST_DLD;
				end
				ST_DLD: begin
					old_q <= ce_rd;
					if (cnt_rd == '0) begin
						fresh_q <= '0;
						state_q <= ST_DDIF;
					end else begin
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					if (div_done) begin
						fresh_q <= div_q;
						state_q <= ST_DDIF;
					end
				end
				ST_DDIF: begin
					mag_q   <= dif_mag[31:0];
					state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					state_q <= ST_DACC;
				end
				ST_DACC: begin
					if (!f_last) begin
						acc_q   <= acc_next;
						f_q     <= f_q + 1'b1;
						state_q <= ST_DRD;
					end else begin
						acc_q <= '0;
						f_q   <= '0;
						if (acc_next > maxs_q) begin
							maxs_q <= acc_next;
						end
						if (!c_last) begin
							c_q     <= c_q + 1'b1;
							state_q <= ST_DRD;
						end else begin
							c_q     <= '0;
							state_q <= ST_DEND;
						end
					end
				end
				ST_DEND: begin
					if ((maxs_q < thr_sq_q) || (it_q + 16'd1 == max_iter_q)) begin
						out_valid_q <= 1'b1;
						it_out_q    <= it_q + 16'd1;
						conv_out_q  <= maxs_q < thr_sq_q;
						rv_out_q    <= '0;
						rc_out_q    <= '0;
						state_q     <= ST_IDLE;
					end else begin
						it_q    <= it_q + 16'd1;
						state_q <= ST_PASS;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	kce_ram #(.WIDTH(32), .DEPTH(MAX_POINTS * FEATURES)) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (value),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	kce_ram #(.WIDTH(CI_W), .DEPTH(MAX_POINTS)) u_assign_ram (
		.clk   (clk),
		.we    (as_we),
		.waddr (as_waddr),
		.wdata (as_wdata),
		.raddr (as_raddr),
		.rdata (as_rd)
	);

	kce_ram #(.WIDTH(32), .DEPTH(MAX_CLUSTERS * FEATURES)) u_centroid_ram (
		.clk   (clk),
		.we    (ce_we),
		.waddr (ce_waddr),
		.wdata (ce_wdata),
		.raddr (ce_raddr),
		.rdata (ce_rd)
	);

	kce_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS * FEATURES)) u_sum_ram (
		.clk   (clk),
		.we    (su_we),
		.waddr (su_waddr),
		.wdata (su_wdata),
		.raddr (su_raddr),
		.rdata (su_rd)
	);

	kce_div #(.SUM_W(SUM_W), .CNT_W(NP_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (signed'(su_rd)),
		.divisor  (cnt_rd),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_valid       = out_valid_q;
	assign iterations_done = it_out_q;
	assign converged       = conv_out_q;
	assign read_value      = rv_out_q;
	assign read_cluster    = rc_out_q;

endmodule
`default_nettype wire

// ----- sim/tb_kmeans_clustering_engine_unit.sv -----
`timescale 1ns / 1ps
module tb_kmeans_clustering_engine_unit;
	import kce_pkg::*;

	localparam int NPTS = DEF_MAX_POINTS;
	localparam int NFEAT = DEF_FEATURES;
	localparam int NCLU = DEF_MAX_CLUSTERS;
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [15:0] iters;
		logic        conv;
		logic [31:0] rdval;
		logic [3:0]  rdclu;
	} kres_t;

	class kmeans_scoreboard;
		int pts[NPTS * NFEAT];
		bit [3:0] asg[NPTS];
		int cen[NCLU * NFEAT];
		bit [10:0] npoints;
		bit [4:0] nclusters;
		bit [15:0] maxit;
		bit [30:0] thresh;
		kres_t pending_q[$];
		int errors;

		function new();
			foreach (pts[i]) pts[i] = 0;
			foreach (asg[i]) asg[i] = 0;
			foreach (cen[i]) cen[i] = 0;
			npoints = RST_NUM_POINTS;
			nclusters = RST_NUM_CLUSTERS;
			maxit = RST_MAX_ITERATIONS;
			thresh = RST_THRESHOLD;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [30:0] d);
			case (idx)
				REG_NUM_POINTS: npoints = d[10:0];
				REG_NUM_CLUSTERS: nclusters = d[4:0];
				REG_MAX_ITERATIONS: maxit = d[15:0];
				REG_THRESHOLD: thresh = d;
				default: ;
			endcase
		endfunction

		function bit [63:0] dist_sq(int p[NFEAT], int q[NFEAT]);
			bit [64:0] acc;
			longint d;
			bit [63:0] m;
			acc = 0;
			for (int f = 0; f < NFEAT; f++) begin
				d = longint'(p[f]) - longint'(q[f]);
				m = (d < 0) ? -d : d;
				acc = acc + m * m;
				if (acc[64]) acc = {1'b0, {64{1'b1}}};
			end
			return acc[63:0];
		endfunction

		function bit lloyd_pass(int n, int k);
			bit [63:0] thr_sq, peak_move, d, best_d;
			int p[NFEAT], q[NFEAT], fresh[NFEAT];
			longint sums[NCLU * NFEAT];
			int counts[NCLU];
			int best;
			thr_sq = 64'(thresh) * 64'(thresh);
			peak_move = 0;
			for (int i = 0; i < n; i++) begin
				for (int f = 0; f < NFEAT; f++) p[f] = pts[i * NFEAT + f];
				best = 0;
				for (int c = 0; c < k; c++) begin
					for (int f = 0; f < NFEAT; f++) q[f] = cen[c * NFEAT + f];
					d = dist_sq(p, q);
					if (c == 0 || d < best_d) begin
						best_d = d;
						best = c;
					end
				end
				asg[i] = 4'(best);
			end
			foreach (sums[i]) sums[i] = 0;
			foreach (counts[i]) counts[i] = 0;
			for (int i = 0; i < n; i++) begin
				counts[asg[i]]++;
				for (int f = 0; f < NFEAT; f++)
					sums[asg[i] * NFEAT + f] += longint'(pts[i * NFEAT + f]);
			end
			for (int c = 0; c < k; c++) begin
				for (int f = 0; f < NFEAT; f++) begin
					q[f] = cen[c * NFEAT + f];
					fresh[f] = counts[c] != 0 ? int'(sums[c * NFEAT + f] / longint'(counts[c])) : 0;
				end
				d = dist_sq(q, fresh);
				if (d > peak_move) peak_move = d;
				for (int f = 0; f < NFEAT; f++) cen[c * NFEAT + f] = fresh[f];
			end
			return peak_move < thr_sq;
		endfunction

		function void note_input(logic [2:0] kd, logic [9:0] sl, logic [2:0] fi, logic [31:0] v);
			kres_t r;
			int n, k;
			r = '0;
			case (kd)
				KIND_LOAD_POINT: if (fi < NFEAT) pts[sl * NFEAT + fi] = v;
				KIND_LOAD_CENTROID: if (fi < NFEAT && sl < NCLU) cen[sl * NFEAT + fi] = v;
				KIND_RUN: begin
					n = npoints > NPTS ? NPTS : npoints;
					k = nclusters == 0 ? 1 : (nclusters > NCLU ? NCLU : nclusters);
					while (r.iters < maxit) begin
						r.iters++;
						if (lloyd_pass(n, k)) begin
							r.conv = 1;
							break;
						end
					end
					pending_q.push_back(r);
				end
				KIND_READ_CENTROID: begin
					if (fi < NFEAT && sl < NCLU) r.rdval = cen[sl * NFEAT + fi];
					pending_q.push_back(r);
				end
				KIND_READ_CLUSTER: begin
					r.rdclu = asg[sl];
					pending_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_result(kres_t got);
			kres_t want;
			if (pending_q.size() == 0) begin
				report("unexpected transaction", 64'(got), 64'd0);
			end else begin
				want = pending_q.pop_front();
				if (got.iters !== want.iters)
					report("iterations_done", 64'(got.iters), 64'(want.iters));
				if (got.conv !== want.conv)
					report("converged", 64'(got.conv), 64'(want.conv));
				if (got.rdval !== want.rdval)
					report("read_value", 64'(got.rdval), 64'(want.rdval));
				if (got.rdclu !== want.rdclu)
					report("read_cluster", 64'(got.rdclu), 64'(want.rdclu));
			end
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] kind, feature_index;
	logic [9:0] slot;
	logic signed [31:0] value;
	logic [15:0] iterations_done;
	logic converged;
	logic signed [31:0] read_value;
	logic [3:0] read_cluster;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;

	kmeans_scoreboard sb;
	bit loaded[NPTS][NFEAT];
	bit small_vals;

	kmeans_clustering_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .slot(slot), .feature_index(feature_index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.iterations_done(iterations_done), .converged(converged),
		.read_value(read_value), .read_cluster(read_cluster),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("FAILURE");
		$finish;
	end

	task send(logic [2:0] kd, logic [9:0] sl, logic [2:0] fi, logic [31:0] v);
		in_valid <= 1;
		kind <= kd;
		slot <= sl;
		feature_index <= fi;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (kd == KIND_LOAD_POINT && fi < NFEAT) loaded[sl][fi] = 1;
		sb.note_input(kd, sl, fi, v);
		if ($urandom_range(0, 99) < 15) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task drain_idle();
		in_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [30:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	function logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 0;
			default: begin
				if (small_vals) return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
				return $urandom;
			end
		endcase
	endfunction

	task preload(int n);
		for (int i = 0; i < n && i < NPTS; i++)
			for (int f = 0; f < NFEAT; f++)
				if (!loaded[i][f]) send(KIND_LOAD_POINT, 10'(i), 3'(f), rand_value());
	endtask

	task phase(int np, int nc, int mi, int th, int count, int runs, bit sm);
		int r, nact;
		logic [9:0] rsl;
		logic [2:0] rfi;
		drain_idle();
		write_reg(REG_NUM_POINTS, 31'(np));
		write_reg(REG_NUM_CLUSTERS, 31'(nc));
		write_reg(REG_MAX_ITERATIONS, 31'(mi));
		write_reg(REG_THRESHOLD, 31'(th));
		cfg_we <= 0;
		small_vals = sm;
		preload(np);
		nact = np > NPTS ? NPTS : (np == 0 ? 1 : np);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < runs) begin
				send(KIND_RUN, 10'($urandom), 3'($urandom), $urandom);
			end else if (r < 35) begin
				rsl = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, nact - 1));
				rfi = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, NFEAT - 1));
				send(KIND_LOAD_POINT, rsl, rfi, rand_value());
			end else if (r < 55) begin
				rsl = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, NCLU - 1));
				rfi = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, NFEAT - 1));
				send(KIND_LOAD_CENTROID, rsl, rfi, rand_value());
			end else if (r < 75) begin
				rsl = ($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, NCLU - 1));
				send(KIND_READ_CENTROID, rsl, 3'($urandom), $urandom);
			end else if (r < 93) begin
				send(KIND_READ_CLUSTER, 10'($urandom), 3'($urandom), $urandom);
			end else begin
				send(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)), 10'($urandom),
					3'($urandom), $urandom);
			end
		end
	endtask

	initial begin
		int cyc;
		kres_t got;
		out_ready = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.iters = iterations_done;
				got.conv = converged;
				got.rdval = read_value;
				got.rdclu = read_cluster;
				sb.check_result(got);
			end
			cyc++;
			if (cyc >= 3000 && cyc < 6000)
				out_ready <= 0;
			else
				case ((cyc / 300) % 3)
					0: out_ready <= 1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= $urandom_range(0, 9) == 0;
				endcase
		end
	end

	initial begin
		sb = new();
		in_valid = 0;
		kind = KIND_LOAD_POINT;
		slot = 0;
		feature_index = 0;
		value = 0;
		cfg_we = 0;
		cfg_index = REG_NUM_POINTS;
		cfg_data = 0;
		small_vals = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(KIND_READ_CLUSTER, 0, 0, 0);
		send(KIND_READ_CENTROID, 0, 0, 0);
		send(KIND_LOAD_POINT, 0, 0, 32'h7fffffff);
		send(KIND_LOAD_POINT, 0, 1, 32'h80000000);
		send(KIND_LOAD_POINT, 0, 2, 32'hffffffff);
		send(KIND_LOAD_POINT, 0, 3, 0);
		send(KIND_LOAD_POINT, 1023, 7, 32'h12345678);
		send(KIND_LOAD_CENTROID, 1, 0, 32'h80000000);
		send(KIND_LOAD_CENTROID, 1, 1, 32'h7fffffff);
		send(KIND_LOAD_CENTROID, 1023, 0, 32'h7fffffff);
		send(KIND_LOAD_CENTROID, 15, 3, 32'h00010000);
		send(KIND_LOAD_CENTROID, 2, 5, 32'h00010000);
		send(KIND_UNUSED_LO, 0, 0, 0);
		send(KIND_UNUSED_HI, 1023, 7, 32'hffffffff);
		send(KIND_READ_CENTROID, 1, 1, 0);
		send(KIND_READ_CENTROID, 15, 3, 0);
		send(KIND_RUN, 0, 0, 0);
		send(KIND_READ_CENTROID, 0, 0, 0);
		send(KIND_READ_CENTROID, 0, 7, 0);
		send(KIND_READ_CENTROID, 1023, 0, 0);
		send(KIND_READ_CLUSTER, 0, 0, 0);
		send(KIND_READ_CLUSTER, 1023, 0, 0);
		send(KIND_RUN, 1023, 7, 32'hffffffff);

		phase(1, 2, 100, 66, 120, 4, 0);
		phase(0, 0, 3, 0, 100, 4, 0);
		phase(12, 4, 5, 0, 130, 3, 0);
		phase(8, 31, 65535, 32'h7fffffff, 120, 4, 1);
		phase(5, 1, 0, 1000, 80, 5, 0);
		phase(16, 16, 4, 1000, 120, 3, 1);
		phase(40, 16, 1, 66, 60, 0, 0);
		send(KIND_RUN, 0, 0, 0);
		for (int i = 0; i < 10; i++) send(KIND_READ_CLUSTER, 10'($urandom), 0, 0);
		phase(3, 2, 2, 5, 30, 5, 0);

		drain_idle();
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
